[hw/rtl/vrn_pkg.sv]
// ----------------------------------------------------------------------------
// vrn_pkg
// shared types and constants of the normalized refraction pipeline
// ----------------------------------------------------------------------------
package vrn_pkg;

    localparam int FRAC       = 14;
    localparam int RDIV_STEPS = 27;
    localparam int SQRT_STEPS = 31;

    localparam logic signed [63:0] ONE_Q    = 64'sd16384;
    localparam logic [26:0]        RDIV_ONE = 27'd67108864;
    localparam logic [63:0]        HALF_LSB = 64'd8192;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NEG_RAD   = 2'd1;
    localparam logic [1:0] STATUS_SHORT     = 2'd2;
    localparam logic [1:0] STATUS_ZERO_COEF = 2'd3;

    typedef struct packed {
        logic [61:0] x;
        logic [61:0] res;
    } sqrt_t;

    typedef struct packed {
        logic [2:0][15:0] dv;
        logic [2:0][15:0] nv;
        logic [15:0]      c;
        logic             zero;
        logic [2:0][31:0] pdn;
        logic [19:0]      d;
        logic [39:0]      pdd;
        logic [23:0]      t0;
        logic [16:0]      rrem;
        logic [26:0]      rnum;
        logic [26:0]      rq;
        logic [51:0]      ptr;
        logic [34:0]      t1;
        logic [49:0]      plo;
        logic [48:0]      phi;
        logic [63:0]      ptt;
        logic [48:0]      t;
        logic             neg;
        sqrt_t            sq_st;
        logic [30:0]      sq;
        logic [2:0][35:0] pa;
        logic [2:0][47:0] pb;
        logic [2:0][20:0] e;
        logic [2:0][32:0] f;
        logic [2:0][48:0] g;
        logic [2:0][33:0] h;
        logic [2:0][35:0] v;
        logic [2:0]       neg_v;
        logic [2:0][34:0] m;
        logic             shn;
        logic [2:0][29:0] ms;
        logic [2:0][59:0] psq;
        logic [30:0]      len;
        logic [1:0]       status;
        logic [2:0][31:0] qnum;
        logic [2:0][31:0] qrem;
        logic [2:0][31:0] qq;
        logic [2:0][31:0] ox;
    } ctx_t;

endpackage

[hw/rtl/vector3_refract_normalized_core.sv]
// ----------------------------------------------------------------------------
// vector3_refract_normalized_core
// refracts a direction at a surface normal and scales the result to unit length
// ----------------------------------------------------------------------------
// throughput: one transaction per cycle while the result is not stalled; the divider,
//   square root and quotient steps are fully pipelined (one step per register stage)
// a stalled result holds the whole pipeline; nothing is lost or repeated
// reset clears all valid bits and sets min_length to 1
module vector3_refract_normalized_core
    import vrn_pkg::*;
#(
    parameter int COMPONENT_WIDTH = 16
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [14:0]                       cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [COMPONENT_WIDTH-1:0] dir_x,
    input  logic signed [COMPONENT_WIDTH-1:0] dir_y,
    input  logic signed [COMPONENT_WIDTH-1:0] dir_z,
    input  logic signed [COMPONENT_WIDTH-1:0] norm_x,
    input  logic signed [COMPONENT_WIDTH-1:0] norm_y,
    input  logic signed [COMPONENT_WIDTH-1:0] norm_z,
    input  logic [15:0]                       index_ratio,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [COMPONENT_WIDTH-1:0] out_x,
    output logic signed [COMPONENT_WIDTH-1:0] out_y,
    output logic signed [COMPONENT_WIDTH-1:0] out_z,
    output logic [1:0]                        status
);

    localparam int ALIGN_DN = (COMPONENT_WIDTH > 16) ? COMPONENT_WIDTH - 16 : 0;
    localparam int ALIGN_UP = (COMPONENT_WIDTH < 16) ? 16 - COMPONENT_WIDTH : 0;
    localparam int QSHIFT   = COMPONENT_WIDTH - 2;
    localparam int QSTEPS   = COMPONENT_WIDTH - 1;
    localparam int QALIGN   = 33 - COMPONENT_WIDTH;

    localparam int ST_LOAD   = 0;
    localparam int ST_DNMUL  = 1;
    localparam int ST_DOT    = 2;
    localparam int ST_DDMUL  = 3;
    localparam int ST_T0     = 4;
    localparam int ST_RDIV   = 5;
    localparam int ST_TRMUL  = ST_RDIV + RDIV_STEPS;
    localparam int ST_T1     = ST_TRMUL + 1;
    localparam int ST_T1RMUL = ST_T1 + 1;
    localparam int ST_TSUM   = ST_T1RMUL + 1;
    localparam int ST_T      = ST_TSUM + 1;
    localparam int ST_RAD    = ST_T + 1;
    localparam int ST_SQ1    = ST_RAD + 1;
    localparam int ST_NMUL   = ST_SQ1 + SQRT_STEPS;
    localparam int ST_EF     = ST_NMUL + 1;
    localparam int ST_GMUL   = ST_EF + 1;
    localparam int ST_H      = ST_GMUL + 1;
    localparam int ST_V      = ST_H + 1;
    localparam int ST_MAG    = ST_V + 1;
    localparam int ST_SCALE  = ST_MAG + 1;
    localparam int ST_SQR    = ST_SCALE + 1;
    localparam int ST_SUM    = ST_SQR + 1;
    localparam int ST_SQ2    = ST_SUM + 1;
    localparam int ST_QINIT  = ST_SQ2 + SQRT_STEPS;
    localparam int ST_QDIV   = ST_QINIT + 1;
    localparam int ST_OUT    = ST_QDIV + QSTEPS;
    localparam int NSTG      = ST_OUT + 1;

    ctx_t             pipe_reg  [NSTG];
    ctx_t             pipe_next [NSTG];
    logic [NSTG-1:0]  vld_reg;
    logic [14:0]      min_length_reg;
    logic             adv;

    function automatic logic signed [63:0] fround(input logic signed [63:0] p);
        logic [63:0] mg;
        logic [63:0] q;
        mg = p[63] ? 64'(-p) : 64'(p);
        q  = (mg + HALF_LSB) >> FRAC;
        return p[63] ? $signed(-q) : $signed(q);
    endfunction

    function automatic logic [15:0] align(input logic signed [COMPONENT_WIDTH-1:0] a);
        return 16'($signed(a) >>> ALIGN_DN) << ALIGN_UP;
    endfunction

    function automatic sqrt_t sqrt_step(input sqrt_t cur, input logic [61:0] bitv);
        sqrt_t       nx;
        logic [61:0] trial;
        trial = cur.res + bitv;
        if (cur.x >= trial)
        begin
            nx.x   = cur.x - trial;
            nx.res = (cur.res >> 1) + bitv;
        end
        else
        begin
            nx.x   = cur.x;
            nx.res = cur.res >> 1;
        end
        return nx;
    endfunction

    assign adv       = !vld_reg[NSTG-1] || out_ready;
    assign in_ready  = adv;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        logic [16:0]        rt17;
        logic [31:0]        rt32;
        logic signed [63:0] rad;
        logic signed [35:0] vv;
        logic signed [35:0] mg36;
        logic [34:0]        orr;
        logic [2:0]         sh;
        logic               short;
        logic [30:0]        len;
        logic [61:0]        nq;
        logic [31:0]        qv;
        rt17  = '0;
        rt32  = '0;
        rad   = '0;
        vv    = '0;
        mg36  = '0;
        orr   = '0;
        sh    = '0;
        short = 1'b0;
        len   = '0;
        nq    = '0;
        qv    = '0;

        for (int s = 1; s < NSTG; s++)
        begin
            pipe_next[s] = pipe_reg[s-1];
        end

        pipe_next[ST_LOAD]       = '0;
        pipe_next[ST_LOAD].dv[0] = align(dir_x);
        pipe_next[ST_LOAD].dv[1] = align(dir_y);
        pipe_next[ST_LOAD].dv[2] = align(dir_z);
        pipe_next[ST_LOAD].nv[0] = align(norm_x);
        pipe_next[ST_LOAD].nv[1] = align(norm_y);
        pipe_next[ST_LOAD].nv[2] = align(norm_z);
        pipe_next[ST_LOAD].c     = index_ratio;
        pipe_next[ST_LOAD].zero  = (index_ratio == 16'd0);

        for (int i = 0; i < 3; i++)
        begin
            pipe_next[ST_DNMUL].pdn[i] = $signed(pipe_reg[ST_DNMUL-1].dv[i])
                                       * $signed(pipe_reg[ST_DNMUL-1].nv[i]);
        end

        pipe_next[ST_DOT].d = 20'(fround(64'($signed(pipe_reg[ST_DOT-1].pdn[0])))
                                + fround(64'($signed(pipe_reg[ST_DOT-1].pdn[1])))
                                + fround(64'($signed(pipe_reg[ST_DOT-1].pdn[2]))));

        pipe_next[ST_DDMUL].pdd = $signed(pipe_reg[ST_DDMUL-1].d)
                                * $signed(pipe_reg[ST_DDMUL-1].d);

        pipe_next[ST_T0].t0   = 24'(ONE_Q - fround(64'($signed(pipe_reg[ST_T0-1].pdd))));
        pipe_next[ST_T0].rnum = RDIV_ONE + 27'(pipe_reg[ST_T0-1].c >> 1);
        pipe_next[ST_T0].rrem = '0;
        pipe_next[ST_T0].rq   = '0;

        // reciprocal, one quotient bit per stage
        for (int k = 0; k < RDIV_STEPS; k++)
        begin
            rt17 = {pipe_reg[ST_RDIV+k-1].rrem[15:0], pipe_reg[ST_RDIV+k-1].rnum[26]};
            pipe_next[ST_RDIV+k].rnum = pipe_reg[ST_RDIV+k-1].rnum << 1;
            if (rt17 >= {1'b0, pipe_reg[ST_RDIV+k-1].c})
            begin
                pipe_next[ST_RDIV+k].rrem = rt17 - {1'b0, pipe_reg[ST_RDIV+k-1].c};
                pipe_next[ST_RDIV+k].rq   = {pipe_reg[ST_RDIV+k-1].rq[25:0], 1'b1};
            end
            else
            begin
                pipe_next[ST_RDIV+k].rrem = rt17;
                pipe_next[ST_RDIV+k].rq   = {pipe_reg[ST_RDIV+k-1].rq[25:0], 1'b0};
            end
        end

        pipe_next[ST_TRMUL].ptr = $signed(pipe_reg[ST_TRMUL-1].t0)
                                * $signed({1'b0, pipe_reg[ST_TRMUL-1].rq});

        pipe_next[ST_T1].t1 = 35'(fround(64'($signed(pipe_reg[ST_T1-1].ptr))));

        // split product against the reciprocal
        pipe_next[ST_T1RMUL].plo = $signed(pipe_reg[ST_T1RMUL-1].t1)
                                 * $signed({1'b0, pipe_reg[ST_T1RMUL-1].rq[13:0]});
        pipe_next[ST_T1RMUL].phi = $signed(pipe_reg[ST_T1RMUL-1].t1)
                                 * $signed({1'b0, pipe_reg[ST_T1RMUL-1].rq[26:14]});

        pipe_next[ST_TSUM].ptt = (64'($signed(pipe_reg[ST_TSUM-1].phi)) << FRAC)
                               + 64'($signed(pipe_reg[ST_TSUM-1].plo));

        pipe_next[ST_T].t = 49'(fround($signed(pipe_reg[ST_T-1].ptt)));

        rad = ONE_Q - 64'($signed(pipe_reg[ST_RAD-1].t));
        pipe_next[ST_RAD].neg       = rad[63];
        pipe_next[ST_RAD].sq_st.x   = rad[63] ? 62'd0 : 62'(rad << FRAC);
        pipe_next[ST_RAD].sq_st.res = '0;

        for (int k = 0; k < SQRT_STEPS; k++)
        begin
            pipe_next[ST_SQ1+k].sq_st = sqrt_step(pipe_reg[ST_SQ1+k-1].sq_st,
                                                  62'(1) << (2 * (SQRT_STEPS - 1 - k)));
        end

        pipe_next[ST_NMUL].sq = pipe_reg[ST_NMUL-1].sq_st.res[30:0];
        for (int i = 0; i < 3; i++)
        begin
            pipe_next[ST_NMUL].pa[i] = $signed(pipe_reg[ST_NMUL-1].nv[i])
                                     * $signed(pipe_reg[ST_NMUL-1].d);
            pipe_next[ST_NMUL].pb[i] = $signed(pipe_reg[ST_NMUL-1].nv[i])
                                     * $signed({1'b0, pipe_reg[ST_NMUL-1].sq_st.res[30:0]});
        end

        for (int i = 0; i < 3; i++)
        begin
            pipe_next[ST_EF].e[i] = 21'(fround(64'($signed(pipe_reg[ST_EF-1].pa[i]))));
            pipe_next[ST_EF].f[i] = 33'(fround(64'($signed(pipe_reg[ST_EF-1].pb[i]))));
            pipe_next[ST_GMUL].g[i] = $signed(pipe_reg[ST_GMUL-1].e[i])
                                    * $signed({1'b0, pipe_reg[ST_GMUL-1].rq});
            pipe_next[ST_H].h[i] = 34'(fround(64'($signed(pipe_reg[ST_H-1].g[i]))));
            pipe_next[ST_V].v[i] = 36'(64'($signed(pipe_reg[ST_V-1].dv[i]))
                                     - 64'($signed(pipe_reg[ST_V-1].h[i]))
                                     - 64'($signed(pipe_reg[ST_V-1].f[i])));
            vv   = $signed(pipe_reg[ST_MAG-1].v[i]);
            mg36 = vv[35] ? -vv : vv;
            pipe_next[ST_MAG].neg_v[i] = vv[35];
            pipe_next[ST_MAG].m[i]     = mg36[34:0];
        end

        // halve until every magnitude is below 2^30
        orr = pipe_reg[ST_SCALE-1].m[0] | pipe_reg[ST_SCALE-1].m[1]
            | pipe_reg[ST_SCALE-1].m[2];
        if (orr[34])
            sh = 3'd5;
        else if (orr[33])
            sh = 3'd4;
        else if (orr[32])
            sh = 3'd3;
        else if (orr[31])
            sh = 3'd2;
        else if (orr[30])
            sh = 3'd1;
        else
            sh = 3'd0;
        pipe_next[ST_SCALE].shn = |orr[34:30];
        for (int i = 0; i < 3; i++)
        begin
            pipe_next[ST_SCALE].ms[i] = 30'(pipe_reg[ST_SCALE-1].m[i] >> sh);
            pipe_next[ST_SQR].psq[i]  = pipe_reg[ST_SQR-1].ms[i] * pipe_reg[ST_SQR-1].ms[i];
        end

        pipe_next[ST_SUM].sq_st.x   = 62'(pipe_reg[ST_SUM-1].psq[0])
                                    + 62'(pipe_reg[ST_SUM-1].psq[1])
                                    + 62'(pipe_reg[ST_SUM-1].psq[2]);
        pipe_next[ST_SUM].sq_st.res = '0;

        for (int k = 0; k < SQRT_STEPS; k++)
        begin
            pipe_next[ST_SQ2+k].sq_st = sqrt_step(pipe_reg[ST_SQ2+k-1].sq_st,
                                                  62'(1) << (2 * (SQRT_STEPS - 1 - k)));
        end

        len   = pipe_reg[ST_QINIT-1].sq_st.res[30:0];
        short = (len == 31'd0)
             || (!pipe_reg[ST_QINIT-1].shn && (len < {16'd0, min_length_reg}));
        pipe_next[ST_QINIT].len = len;
        if (pipe_reg[ST_QINIT-1].zero)
            pipe_next[ST_QINIT].status = STATUS_ZERO_COEF;
        else if (pipe_reg[ST_QINIT-1].neg)
            pipe_next[ST_QINIT].status = STATUS_NEG_RAD;
        else if (short)
            pipe_next[ST_QINIT].status = STATUS_SHORT;
        else
            pipe_next[ST_QINIT].status = STATUS_OK;
        for (int i = 0; i < 3; i++)
        begin
            nq = (62'(pipe_reg[ST_QINIT-1].ms[i]) << QSHIFT) + 62'(len >> 1);
            pipe_next[ST_QINIT].qrem[i] = 32'(nq >> QSTEPS);
            pipe_next[ST_QINIT].qnum[i] = nq[31:0] << QALIGN;
            pipe_next[ST_QINIT].qq[i]   = '0;
        end

        // quotient by the length, one bit per stage
        for (int k = 0; k < QSTEPS; k++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                rt32 = {pipe_reg[ST_QDIV+k-1].qrem[i][30:0], pipe_reg[ST_QDIV+k-1].qnum[i][31]};
                pipe_next[ST_QDIV+k].qnum[i] = pipe_reg[ST_QDIV+k-1].qnum[i] << 1;
                if (rt32 >= {1'b0, pipe_reg[ST_QDIV+k-1].len})
                begin
                    pipe_next[ST_QDIV+k].qrem[i] = rt32 - {1'b0, pipe_reg[ST_QDIV+k-1].len};
                    pipe_next[ST_QDIV+k].qq[i]   = {pipe_reg[ST_QDIV+k-1].qq[i][30:0], 1'b1};
                end
                else
                begin
                    pipe_next[ST_QDIV+k].qrem[i] = rt32;
                    pipe_next[ST_QDIV+k].qq[i]   = {pipe_reg[ST_QDIV+k-1].qq[i][30:0], 1'b0};
                end
            end
        end

        for (int i = 0; i < 3; i++)
        begin
            qv = pipe_reg[ST_OUT-1].qq[i];
            if (pipe_reg[ST_OUT-1].status != STATUS_OK)
                pipe_next[ST_OUT].ox[i] = '0;
            else if (pipe_reg[ST_OUT-1].neg_v[i])
                pipe_next[ST_OUT].ox[i] = -qv;
            else
                pipe_next[ST_OUT].ox[i] = qv;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg        <= '0;
            min_length_reg <= 15'd1;
        end
        else
        begin
            if (adv)
            begin
                vld_reg <= {vld_reg[NSTG-2:0], in_valid};
            end
            if (cfg_valid)
            begin
                min_length_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int s = 0; s < NSTG; s++)
            begin
                pipe_reg[s] <= pipe_next[s];
            end
        end
    end

    assign out_valid = vld_reg[NSTG-1];
    assign out_x     = pipe_reg[ST_OUT].ox[0][COMPONENT_WIDTH-1:0];
    assign out_y     = pipe_reg[ST_OUT].ox[1][COMPONENT_WIDTH-1:0];
    assign out_z     = pipe_reg[ST_OUT].ox[2][COMPONENT_WIDTH-1:0];
    assign status    = pipe_reg[ST_OUT].status;

endmodule

[hw/rtl/vrn_checker.sv]
// ----------------------------------------------------------------------------
// vrn_checker
// port-level checks of the normalized refraction core, bound to the top level
// ----------------------------------------------------------------------------
module vrn_checker
    import vrn_pkg::*;
#(
    parameter int COMPONENT_WIDTH = 16
)
(
    input logic                              clk,
    input logic                              rst_n,
    input logic                              cfg_valid,
    input logic                              cfg_ready,
    input logic [14:0]                       cfg_data,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic signed [COMPONENT_WIDTH-1:0] dir_x,
    input logic signed [COMPONENT_WIDTH-1:0] dir_y,
    input logic signed [COMPONENT_WIDTH-1:0] dir_z,
    input logic signed [COMPONENT_WIDTH-1:0] norm_x,
    input logic signed [COMPONENT_WIDTH-1:0] norm_y,
    input logic signed [COMPONENT_WIDTH-1:0] norm_z,
    input logic [15:0]                       index_ratio,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic signed [COMPONENT_WIDTH-1:0] out_x,
    input logic signed [COMPONENT_WIDTH-1:0] out_y,
    input logic signed [COMPONENT_WIDTH-1:0] out_z,
    input logic [1:0]                        status
);

    localparam int UNIT = 1 << (COMPONENT_WIDTH - 2);

    // failed transaction carries a zero vector
    a_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != STATUS_OK)
        |-> (out_x == '0) && (out_y == '0) && (out_z == '0))
        else $error("nonzero vector with failure status");

    // normalized components never exceed one
    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == STATUS_OK)
        |-> ($signed(out_x) <= UNIT) && ($signed(out_x) >= -UNIT)
         && ($signed(out_y) <= UNIT) && ($signed(out_y) >= -UNIT)
         && ($signed(out_z) <= UNIT) && ($signed(out_z) >= -UNIT))
        else $error("normalized component out of range");

    // input side moves whenever the output side can
    a_ready_link: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("input ready does not follow output state");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready
        |=> out_valid && $stable(out_x) && $stable(out_y) && $stable(out_z)
            && $stable(status))
        else $error("stalled result changed");

endmodule

bind vector3_refract_normalized_core vrn_checker #(
    .COMPONENT_WIDTH(COMPONENT_WIDTH)
) u_vrn_checker (.*);

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the normalized refraction core: random and directed
// vectors, a fixed-point predictor of the refracted unit vector, random gaps
// and stalls, and min_length changes between phases
// ----------------------------------------------------------------------------
module testbench;
    import vrn_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [15:0] dx;
        logic signed [15:0] dy;
        logic signed [15:0] dz;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
        logic [15:0]        coef;
    } ray_t;

    typedef struct packed {
        logic signed [15:0] ox;
        logic signed [15:0] oy;
        logic signed [15:0] oz;
        logic [1:0]         st;
    } unit_vec_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [14:0]        cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic signed [15:0] dir_x = '0;
    logic signed [15:0] dir_y = '0;
    logic signed [15:0] dir_z = '0;
    logic signed [15:0] norm_x = '0;
    logic signed [15:0] norm_y = '0;
    logic signed [15:0] norm_z = '0;
    logic [15:0]        index_ratio = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic signed [15:0] out_z;
    logic [1:0]         status;

    ray_t      ray_q[$];
    unit_vec_t refracted_q[$];
    logic [14:0] min_len_model = 15'd1;
    logic      steady = 1'b0;
    logic      hold_go = 1'b0;
    int        hold_left = 0;
    int        gap_left = 0;
    int        stall_left = 0;
    int        errors = 0;
    int        checked = 0;
    int        sent = 0;
    int        by_status[4] = '{0, 0, 0, 0};

    vector3_refract_normalized_core #(.COMPONENT_WIDTH(16)) dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z),
        .norm_x(norm_x), .norm_y(norm_y), .norm_z(norm_z),
        .index_ratio(index_ratio),
        .out_valid(out_valid), .out_ready(out_ready),
        .out_x(out_x), .out_y(out_y), .out_z(out_z), .status(status)
    );

    always #6 clk = ~clk;

    function automatic longint unsigned magn(longint a);
        return (a < 0) ? longint'(-a) : a;
    endfunction

    function automatic longint qmul(longint a, longint b);
        logic              neg;
        longint unsigned   p;
        neg = (a < 0) != (b < 0);
        p = (magn(a) * magn(b) + 64'd8192) >> FRAC;
        return neg ? -longint'(p) : longint'(p);
    endfunction

    function automatic longint unsigned root_floor(longint unsigned x);
        longint unsigned res;
        longint unsigned bits;
        res = 0;
        bits = 64'd1 << 62;
        while (bits > x) bits = bits >> 2;
        while (bits != 0)
        begin
            if (x >= res + bits)
            begin
                x = x - (res + bits);
                res = (res >> 1) + bits;
            end
            else
                res = res >> 1;
            bits = bits >> 2;
        end
        return res;
    endfunction

    function automatic unit_vec_t refract_unit(ray_t it, logic [14:0] min_len);
        longint          dv[3];
        longint          nv[3];
        longint          v[3];
        longint unsigned m[3];
        longint unsigned r;
        longint unsigned len;
        longint unsigned q;
        longint          d;
        longint          t;
        longint          rad;
        longint          sq;
        longint          o;
        int              sh;
        unit_vec_t       res;
        res = '0;
        res.st = STATUS_OK;
        sh = 0;
        dv[0] = it.dx; dv[1] = it.dy; dv[2] = it.dz;
        nv[0] = it.nx; nv[1] = it.ny; nv[2] = it.nz;
        if (it.coef == 0)
            res.st = STATUS_ZERO_COEF;
        else
        begin
            r = ((64'd1 << 26) + it.coef / 2) / it.coef;
            d = qmul(dv[0], nv[0]) + qmul(dv[1], nv[1]) + qmul(dv[2], nv[2]);
            t = ONE_Q - qmul(d, d);
            t = qmul(qmul(t, longint'(r)), longint'(r));
            rad = ONE_Q - t;
            if (rad < 0)
                res.st = STATUS_NEG_RAD;
            else
            begin
                sq = longint'(root_floor(longint'(rad) << FRAC));
                for (int i = 0; i < 3; i++)
                begin
                    v[i] = dv[i] - qmul(qmul(nv[i], d), longint'(r)) - qmul(nv[i], sq);
                    m[i] = magn(v[i]);
                end
                while (m[0] >= (64'd1 << 30) || m[1] >= (64'd1 << 30)
                       || m[2] >= (64'd1 << 30))
                begin
                    for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
                    sh++;
                end
                len = root_floor(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
                if (len == 0 || (sh == 0 && len < min_len))
                    res.st = STATUS_SHORT;
                else
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        q = ((m[i] << 14) + len / 2) / len;
                        o = (v[i] < 0) ? -longint'(q) : longint'(q);
                        if (i == 0) res.ox = o[15:0];
                        else if (i == 1) res.oy = o[15:0];
                        else res.oz = o[15:0];
                    end
                end
            end
        end
        return res;
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (steady || p < 60) return 0;
        if (p < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        errors++;
        $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want, checked);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin : drive_blk
        ray_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                refracted_q.push_back(refract_unit({dir_x, dir_y, dir_z, norm_x, norm_y,
                                                    norm_z, index_ratio}, min_len_model));
                sent++;
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (ray_q.size() > 0)
                begin
                    nxt = ray_q.pop_front();
                    dir_x <= nxt.dx; dir_y <= nxt.dy; dir_z <= nxt.dz;
                    norm_x <= nxt.nx; norm_y <= nxt.ny; norm_z <= nxt.nz;
                    index_ratio <= nxt.coef;
                    in_valid <= 1'b1;
                    gap_left <= pick_gap();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off
    always @(posedge clk)
    begin
        if (hold_go)
            hold_left <= 600;
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin : mon_blk
        unit_vec_t want;
        int p;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                checked++;
                if (refracted_q.size() == 0)
                    report_mismatch("unexpected transaction status", status, -1);
                else
                begin
                    want = refracted_q.pop_front();
                    by_status[want.st]++;
                    if (out_x !== want.ox) report_mismatch("out_x", out_x, want.ox);
                    if (out_y !== want.oy) report_mismatch("out_y", out_y, want.oy);
                    if (out_z !== want.oz) report_mismatch("out_z", out_z, want.oz);
                    if (status !== want.st) report_mismatch("status", status, want.st);
                end
            end
            p = $urandom_range(0, 99);
            if (hold_go || hold_left > 1)
                out_ready <= 1'b0;
            else if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                out_ready <= 1'b0;
            end
            else if (steady || p >= 25)
                out_ready <= 1'b1;
            else
            begin
                out_ready <= 1'b0;
                stall_left <= (p < 2) ? $urandom_range(15, 50) : $urandom_range(0, 2);
            end
        end
    end

    // sampled away from the active edge so the driver and monitor have settled
    task automatic wait_drained();
        while (ray_q.size() > 0 || in_valid || refracted_q.size() > 0) @(negedge clk);
        repeat (140) @(posedge clk);
    endtask

    task automatic write_min_len(logic [14:0] val);
        wait_drained();
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        min_len_model = val;
    endtask

    task automatic add_ray(int dx, int dy, int dz, int nx, int ny, int nz, int c);
        ray_t it;
        it.dx = 16'(dx); it.dy = 16'(dy); it.dz = 16'(dz);
        it.nx = 16'(nx); it.ny = 16'(ny); it.nz = 16'(nz);
        it.coef = 16'(c);
        ray_q.push_back(it);
    endtask

    function automatic int rnd_comp(int kind);
        case (kind)
            0: return $urandom_range(0, 65535) - 32768;
            1: return $urandom_range(0, 32768) - 16384;
            default: return $urandom_range(0, 2048) - 1024;
        endcase
    endfunction

    task automatic add_random(int n);
        int kind;
        int c;
        int p;
        for (int k = 0; k < n; k++)
        begin
            p = $urandom_range(0, 99);
            kind = (p < 20) ? 0 : (p < 90) ? 1 : 2;
            p = $urandom_range(0, 99);
            if (p < 3) c = 0;
            else if (p < 20) c = $urandom_range(0, 65535);
            else if (p < 25) c = $urandom_range(1, 64);
            else c = $urandom_range(2048, 8192);
            add_ray(rnd_comp(kind), rnd_comp(kind), rnd_comp(kind),
                    rnd_comp(kind), rnd_comp(kind), rnd_comp(kind), c);
        end
    endtask

    initial
    begin
        logic [14:0] phase_len[5];
        phase_len = '{15'd0, 15'd32767, 15'd1, 15'd16384, 15'd300};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        write_min_len(15'd1);

        // directed: extremes and the special cases
        add_ray(0, 0, -16384, 0, 0, 16384, 4096);
        add_ray(0, 0, -16384, 0, 0, 16384, 0);
        add_ray(16000, 0, -3000, 0, 0, 16384, 2048);
        add_ray(0, 0, 0, 0, 0, 0, 4096);
        add_ray(-32768, -32768, -32768, -32768, -32768, -32768, 65535);
        add_ray(32767, 32767, 32767, 32767, 32767, 32767, 1);
        add_ray(32767, -32768, 32767, -32768, 32767, -32768, 4096);
        add_ray(8000, 8000, -8000, 0, 16384, 0, 1);
        add_ray(1, 0, 0, 0, 0, 0, 65535);
        add_ray(0, 3, 0, 0, 0, 0, 4096);
        add_ray(11585, 0, -11585, 0, 0, 16384, 5461);
        add_ray(11585, 0, -11585, 0, 0, 16384, 3000);
        add_ray(-1, -1, -1, 1, 1, 1, 65535);
        add_ray(0, 0, 16384, 0, 0, 16384, 12288);

        for (int ph = 0; ph < 5; ph++)
        begin
            write_min_len(phase_len[ph]);
            steady = (ph == 2);
            add_random(306);
            if (ph == 1)
            begin
                repeat (20) @(posedge clk);
                hold_go <= 1'b1;
                @(posedge clk);
                hold_go <= 1'b0;
            end
        end
        steady = 1'b0;
        wait_drained();
        $display("%0d rays sent, %0d results checked over five min_length settings",
                 sent, checked);
        $display("status ok %0d, negative radicand %0d, too short %0d, zero coefficient %0d",
                 by_status[0], by_status[1], by_status[2], by_status[3]);
        if (errors == 0)
            $display("PASS vector3_refract_normalized_core");
        else
            $display("FAIL vector3_refract_normalized_core");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("timeout");
        $display("FAIL vector3_refract_normalized_core");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/vrn_pkg.sv
hw/rtl/vector3_refract_normalized_core.sv
hw/rtl/vrn_checker.sv
bench/testbench.sv
